### hdl/kcp_pkg.sv
// ----------------------------------------------------------------------------
// kcp_pkg
// Shared types and constants of the k-core peeling unit: beat structs,
// action and command codes, register indexes and engine states.
// ----------------------------------------------------------------------------
package kcp_pkg;

   localparam int MAX_VERTICES_DEF = 64;
   localparam int VTX_W            = 6;
   localparam int ROW_W            = 64;
   localparam int CFG_W            = 7;
   localparam int CSR_IDX_W        = 1;

   typedef logic [VTX_W-1:0] vtx_type;
   typedef logic [ROW_W-1:0] nbr_type;
   typedef logic [CFG_W-1:0] cfg_type;

   localparam logic [1:0] ACT_ADD   = 2'd0;
   localparam logic [1:0] ACT_PEEL  = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_K_MIN        = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_COUNT = 1'b1;

   localparam cfg_type K_MIN_RST  = 7'd2;
   localparam cfg_type VCOUNT_RST = 7'd64;

   typedef struct packed {
      logic [1:0] action;
      vtx_type    vertex_a;
      vtx_type    vertex_b;
   } req_type;

   typedef struct packed {
      vtx_type vertex_index;
      nbr_type neighbour_row;
      logic    in_core;
      logic    last;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_PEEL  = 2'd1,
      OP_CLEAR = 2'd2
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      vtx_type    vertex_a;
      vtx_type    vertex_b;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_WA,
      ST_ADD_WB,
      ST_SWEEP,
      ST_DRAIN,
      ST_EMIT
   } eng_state_type;

endpackage

### hdl/kcp_front.sv
// ----------------------------------------------------------------------------
// kcp_front
// Accepts request beats, drops edges that change nothing (self-loops,
// endpoints out of use) and unused action codes, and queues the rest.
// ----------------------------------------------------------------------------
module kcp_front #(
   parameter int MAX_VERTICES = kcp_pkg::MAX_VERTICES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  kcp_pkg::req_type                  req_data,
   output logic                              req_stall,
   input  logic [$clog2(MAX_VERTICES+1)-1:0] n_eff,
   output logic                              cmd_valid,
   output kcp_pkg::cmd_type                  cmd,
   input  logic                              cmd_pop
);
   import kcp_pkg::*;

   cmd_type    cmd_in;
   logic       keep;
   logic       push;
   logic       a_used;
   logic       b_used;
   logic [1:0] cnt_ff, cnt_in;
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   cmd_type    slot_ff [2];

   assign a_used = 7'(req_data.vertex_a) < 7'(n_eff);
   assign b_used = 7'(req_data.vertex_b) < 7'(n_eff);

   always_comb begin
      cmd_in.vertex_a = req_data.vertex_a;
      cmd_in.vertex_b = req_data.vertex_b;
      cmd_in.op       = OP_ADD;
      keep            = 1'b0;
      priority if (req_data.action == ACT_ADD) begin
         cmd_in.op = OP_ADD;
         keep      = (req_data.vertex_a != req_data.vertex_b) && a_used && b_used;
      end else if (req_data.action == ACT_PEEL) begin
         cmd_in.op = OP_PEEL;
         keep      = 1'b1;
      end else if (req_data.action == ACT_CLEAR) begin
         cmd_in.op = OP_CLEAR;
         keep      = 1'b1;
      end else begin
         keep = 1'b0;
      end
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall && keep;
   assign cnt_in    = cnt_ff + 2'(push) - 2'(cmd_pop);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (cmd_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

### hdl/kcp_engine.sv
// ----------------------------------------------------------------------------
// kcp_engine
// Back end: holds the adjacency matrix in a row memory, inserts edges,
// clears it, peels in row sweeps (each applies the previous round's peel set
// and counts degrees for the next) and emits one result beat per vertex.
// ----------------------------------------------------------------------------
module kcp_engine #(
   parameter int MAX_VERTICES = kcp_pkg::MAX_VERTICES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  kcp_pkg::cfg_type                  k_min,
   input  logic [$clog2(MAX_VERTICES+1)-1:0] n_eff,
   input  logic                              cmd_valid,
   input  kcp_pkg::cmd_type                  cmd,
   output logic                              cmd_pop,
   output logic                              rsp_valid,
   output kcp_pkg::rsp_type                  rsp_data,
   input  logic                              rsp_stall
);
   import kcp_pkg::*;

   localparam int VW      = $clog2(MAX_VERTICES);
   localparam int CW      = $clog2(MAX_VERTICES+1);
   localparam int NCH     = (MAX_VERTICES + 7) / 8;
   localparam int PAD_W   = NCH * 8;

   typedef logic [MAX_VERTICES-1:0] row_type;
   typedef logic [VW-1:0]           idx_type;
   typedef logic [CW-1:0]           cnt_type;
   typedef logic [PAD_W-1:0]        pad_type;

   eng_state_type state_ff, state_in;

   row_type adj_ff [MAX_VERTICES];
   row_type row_vld_ff;

   logic    rda_en, rdb_en;
   idx_type rda_addr, rdb_addr;
   row_type qa_ff, qb_ff;
   logic    qa_vld_ff, qb_vld_ff;
   row_type rowa, rowb;

   logic    wr_en;
   idx_type wr_addr;
   row_type wr_data;

   row_type mask;
   idx_type va_ff, vb_ff;
   idx_type idx_ff;
   row_type peel_prev_ff, peel_next_ff;

   logic    s1_v_ff, s2_v_ff, s3_v_ff;
   idx_type s1_idx_ff, s2_idx_ff, s3_idx_ff;
   row_type s2_row_ff;
   row_type upd;
   pad_type pad;
   logic [3:0] part_in [NCH];
   logic [3:0] s3_part_ff [NCH];
   cnt_type deg;
   logic    hit;
   logic    drained;
   logic    start_peel;
   logic    start_clear;

   cnt_type e_cnt_ff;
   logic    pend_ff, pend_in;
   idx_type pend_idx_ff;
   logic    out_v_ff, out_v_in;
   rsp_type out_ff, out_in;
   row_type erow;
   logic    out_free, xfer, issue, emit_done;

   // row storage, read-before-write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         adj_ff[wr_addr] <= wr_data;
      end
      if (rda_en) begin
         qa_ff     <= adj_ff[rda_addr];
         qa_vld_ff <= row_vld_ff[rda_addr];
      end
      if (rdb_en) begin
         qb_ff     <= adj_ff[rdb_addr];
         qb_vld_ff <= row_vld_ff[rdb_addr];
      end
   end

   assign rowa = qa_vld_ff ? qa_ff : '0;
   assign rowb = qb_vld_ff ? qb_ff : '0;

   always_comb begin
      for (int j = 0; j < MAX_VERTICES; j++) begin
         mask[j] = 7'(j) < 7'(n_eff);
      end
   end

   assign start_peel  = (state_ff == ST_IDLE) && cmd_valid && (cmd.op == OP_PEEL);
   assign start_clear = (state_ff == ST_IDLE) && cmd_valid && (cmd.op == OP_CLEAR);
   assign drained     = !s1_v_ff && !s2_v_ff && !s3_v_ff;

   // sweep stage 1: apply previous peel set, write back
   assign upd = peel_prev_ff[s1_idx_ff] ? '0 : (rowa & ~peel_prev_ff);

   // sweep stage 2: per-byte counts
   assign pad = pad_type'(s2_row_ff);
   always_comb begin
      for (int c = 0; c < NCH; c++) begin
         part_in[c] = 4'd0;
         for (int b = 0; b < 8; b++) begin
            part_in[c] = part_in[c] + 4'(pad[c*8+b]);
         end
      end
   end

   // sweep stage 3: degree and peel decision
   always_comb begin
      deg = '0;
      for (int c = 0; c < NCH; c++) begin
         deg = deg + cnt_type'(s3_part_ff[c]);
      end
   end
   assign hit = s3_v_ff && (deg != '0) && (7'(deg) < k_min) && (7'(s3_idx_ff) < 7'(n_eff));

   // emission
   assign out_free  = !out_v_ff || !rsp_stall;
   assign xfer      = pend_ff && out_free;
   assign issue     = (state_ff == ST_EMIT) && (e_cnt_ff != n_eff) && (!pend_ff || xfer);
   assign emit_done = (e_cnt_ff == n_eff) && (!pend_ff || xfer);
   assign erow      = rowa & mask;

   always_comb begin
      out_in.vertex_index  = vtx_type'(pend_idx_ff);
      out_in.neighbour_row = nbr_type'(erow);
      out_in.in_core       = (erow != '0);
      out_in.last          = (7'(pend_idx_ff) + 7'd1) == 7'(n_eff);
   end

   always_comb begin
      pend_in = pend_ff;
      if (issue) begin
         pend_in = 1'b1;
      end else if (xfer) begin
         pend_in = 1'b0;
      end
   end

   always_comb begin
      out_v_in = out_v_ff;
      if (xfer) begin
         out_v_in = 1'b1;
      end else if (out_v_ff && !rsp_stall) begin
         out_v_in = 1'b0;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.op)
                  OP_ADD:   state_in = ST_ADD_WA;
                  OP_PEEL:  state_in = ST_SWEEP;
                  OP_CLEAR: state_in = ST_IDLE;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_ADD_WA: state_in = ST_ADD_WB;
         ST_ADD_WB: state_in = ST_IDLE;
         ST_SWEEP: begin
            if (idx_ff == idx_type'(MAX_VERTICES - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (drained) begin
               state_in = (peel_next_ff != '0) ? ST_SWEEP : ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd_pop  = (state_ff == ST_IDLE) && cmd_valid;
      rda_en   = 1'b0;
      rda_addr = idx_ff;
      rdb_en   = 1'b0;
      rdb_addr = vb_ff;
      wr_en    = 1'b0;
      wr_addr  = s1_idx_ff;
      wr_data  = upd;
      unique case (state_ff)
         ST_IDLE: begin
            rda_en   = cmd_valid && (cmd.op == OP_ADD);
            rda_addr = cmd.vertex_a[VW-1:0];
            rdb_en   = cmd_valid && (cmd.op == OP_ADD);
            rdb_addr = cmd.vertex_b[VW-1:0];
         end
         ST_ADD_WA: begin
            wr_en   = 1'b1;
            wr_addr = va_ff;
            wr_data = rowa | (row_type'(1) << vb_ff);
         end
         ST_ADD_WB: begin
            wr_en   = 1'b1;
            wr_addr = vb_ff;
            wr_data = rowb | (row_type'(1) << va_ff);
         end
         ST_SWEEP: begin
            rda_en   = 1'b1;
            rda_addr = idx_ff;
            wr_en    = s1_v_ff;
         end
         ST_DRAIN: begin
            wr_en = s1_v_ff;
         end
         ST_EMIT: begin
            rda_en   = issue;
            rda_addr = e_cnt_ff[VW-1:0];
         end
         default: begin
            rda_en = 1'b0;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_vld_ff   <= '0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         out_v_ff     <= 1'b0;
         peel_prev_ff <= '0;
         peel_next_ff <= '0;
      end else begin
         state_ff <= state_in;
         s1_v_ff  <= (state_ff == ST_SWEEP);
         s2_v_ff  <= s1_v_ff;
         s3_v_ff  <= s2_v_ff;
         pend_ff  <= pend_in;
         out_v_ff <= out_v_in;
         if (start_clear) begin
            row_vld_ff <= '0;
         end else if (wr_en) begin
            row_vld_ff[wr_addr] <= 1'b1;
         end
         if (start_peel) begin
            peel_prev_ff <= '0;
            peel_next_ff <= '0;
         end else if ((state_ff == ST_DRAIN) && drained) begin
            peel_prev_ff <= peel_next_ff;
            peel_next_ff <= '0;
         end else if (hit) begin
            peel_next_ff[s3_idx_ff] <= 1'b1;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if ((state_ff == ST_IDLE) && cmd_valid) begin
         va_ff <= cmd.vertex_a[VW-1:0];
         vb_ff <= cmd.vertex_b[VW-1:0];
      end
      if (start_peel || ((state_ff == ST_DRAIN) && drained)) begin
         idx_ff <= '0;
      end else if (state_ff == ST_SWEEP) begin
         idx_ff <= idx_ff + idx_type'(1);
      end
      s1_idx_ff <= idx_ff;
      s2_idx_ff <= s1_idx_ff;
      s2_row_ff <= upd & mask;
      s3_idx_ff <= s2_idx_ff;
      for (int c = 0; c < NCH; c++) begin
         s3_part_ff[c] <= part_in[c];
      end
      if ((state_ff == ST_DRAIN) && drained) begin
         e_cnt_ff <= '0;
      end else if (issue) begin
         e_cnt_ff <= e_cnt_ff + cnt_type'(1);
      end
      if (issue) begin
         pend_idx_ff <= e_cnt_ff[VW-1:0];
      end
      if (xfer) begin
         out_ff <= out_in;
      end
   end

endmodule

### hdl/k_core_peeling_unit.sv
// Behind a 2-beat command queue that takes one request beat per cycle until
// full, an edge add reads both rows and then writes row a and row b; clear
// drops the row valid bits. Peel: each round is one row sweep of the matrix
// memory plus a 3-stage degree pipeline, then n result beats go out at one
// per cycle while rsp_stall is low. Reset (synchronous): graph empty via
// per-row valid bits, k_min = 2, vertex_count = 64; no clearing pass.
// ----------------------------------------------------------------------------
// k_core_peeling_unit
// k-core decomposition over an adjacency bit matrix: edge loading, round
// based peeling and per-vertex result emission.
// ----------------------------------------------------------------------------
module k_core_peeling_unit #(
   parameter int MAX_VERTICES = kcp_pkg::MAX_VERTICES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  kcp_pkg::req_type                     req_data,
   output logic                                 req_stall,
   output logic                                 rsp_valid,
   output kcp_pkg::rsp_type                     rsp_data,
   input  logic                                 rsp_stall,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [kcp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  kcp_pkg::cfg_type                     csr_wdata
);
   import kcp_pkg::*;

   localparam int CW = $clog2(MAX_VERTICES+1);

   typedef logic [CW-1:0] cnt_type;

   cfg_type k_min_ff;
   cfg_type vcount_ff;
   cnt_type n_eff;
   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_min_ff  <= K_MIN_RST;
         vcount_ff <= VCOUNT_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_K_MIN:        k_min_ff  <= csr_wdata;
            CSR_VERTEX_COUNT: vcount_ff <= csr_wdata;
            default:          k_min_ff  <= k_min_ff;
         endcase
      end
   end

   always_comb begin
      priority if (vcount_ff == '0) begin
         n_eff = cnt_type'(1);
      end else if (vcount_ff > 7'(MAX_VERTICES)) begin
         n_eff = cnt_type'(MAX_VERTICES);
      end else begin
         n_eff = cnt_type'(vcount_ff);
      end
   end

   kcp_front #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .n_eff     (n_eff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   kcp_engine #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .k_min     (k_min_ff),
      .n_eff     (n_eff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   // no vertex is ever its own neighbor
   a_no_self_bit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_data.neighbour_row[rsp_data.vertex_index])
      else $error("result row holds its own vertex bit");

   // queued edges were filtered by the front end
   a_add_filtered: assert property (@(posedge clock) disable iff (reset)
      cmd_valid && (cmd.op == OP_ADD) |-> cmd.vertex_a != cmd.vertex_b)
      else $error("self-loop edge reached the engine");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (7'(n_eff) != 7'd0) && (7'(n_eff) <= 7'(MAX_VERTICES)))
      else $error("effective vertex count out of range");

endmodule
